// ===== hdl/tsg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsg_pkg: shared types and constants of the turtle segment generator
// Position format, command codes and the move word passed from front to back.
// ----------------------------------------------------------------------------
package tsg_pkg;

   // position format: signed, POS_INT_BITS integer and POS_FRAC_BITS fraction bits
   localparam int POS_FRAC_BITS = 16;
   localparam int POS_INT_BITS  = 32;
   localparam int POS_W         = POS_INT_BITS + POS_FRAC_BITS;
   localparam int OUT_W         = 48;

   localparam int HEADING_W = 9;
   localparam int AMOUNT_W  = 16;
   localparam int COLOR_W   = 24;
   localparam int CMD_W     = 3;

   localparam int HALF_TURN    = 180;
   localparam int FULL_TURN    = 2 * HALF_TURN;
   localparam int QUARTER_TURN = HALF_TURN / 2;

   localparam logic [COLOR_W-1:0] RESET_COLOR = 24'h0000FF;

   // command codes
   localparam logic [CMD_W-1:0] CMD_UP    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DOWN  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_RIGHT = 3'd2;
   localparam logic [CMD_W-1:0] CMD_LEFT  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FWD   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_BACK  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_COLOR = 3'd6;

   // step arithmetic: Q1.16 trig value times signed distance
   localparam int DIST_W    = AMOUNT_W + 1;
   localparam int COS_W     = 18;
   localparam int PROD_W    = DIST_W + COS_W;
   localparam int STEP_SHL  = (POS_FRAC_BITS >= 16) ? POS_FRAC_BITS - 16 : 0;
   localparam int STEP_SHR  = (POS_FRAC_BITS < 16) ? 16 - POS_FRAC_BITS : 0;
   localparam int STEP_RND  = (STEP_SHR > 0) ? (1 << (STEP_SHR - 1)) : 0;
   localparam int STEP_W    = PROD_W + STEP_SHL;
   localparam int SUM_W     = ((POS_W > STEP_W) ? POS_W : STEP_W) + 1;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   // one move as handed from the front to the back
   typedef struct packed {
      logic signed [DIST_W-1:0] travel;
      logic signed [COS_W-1:0]  cos_val;
      logic signed [COS_W-1:0]  sin_val;
      logic                     draw;
      logic [COLOR_W-1:0]       color;
   } move_type;

   // one drawn segment, packed lowest field last
   typedef struct packed {
      logic [OUT_W-1:0]   to_y;
      logic [OUT_W-1:0]   to_x;
      logic [OUT_W-1:0]   from_y;
      logic [OUT_W-1:0]   from_x;
      logic [COLOR_W-1:0] seg_color;
   } seg_type;

endpackage

// ===== hdl/tsg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsg_front: command intake and classification
// Keeps heading, pen state and colour; turns moves into queued move words.
// ----------------------------------------------------------------------------
module tsg_front import tsg_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [CMD_W-1:0]    req_tuser,   // cmd
   input  logic [39:0]         req_tdata,   // amount[15:0], rgb[39:16]
   input  logic                fifo_full,
   output logic                push_vld,
   output move_type            push_data
);

   localparam int TAB_N       = QUARTER_TURN + 1;
   localparam int TAB_AW      = $clog2(TAB_N);
   localparam int TURN_RECIP  = 46604;   // ceil(2^24 / 360)
   localparam int TURN_SHIFT  = 24;
   localparam int QUOT_W      = 8;

   typedef logic [TAB_N-1:0][16:0] cos_tab_type;

   // Taylor cosine in Q31, rounded to Q1.16
   function automatic logic [16:0] cos_entry(input int d);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        rnd;
      x    = (64'(d) * 64'd6746518852) / 64'd180;
      x2   = (x * x) >> 31;
      term = 64'd1 << 31;
      sum  = $signed(term);
      term = ((term * x2) >> 31) / 64'd2;   sum = sum - $signed(term);
      term = ((term * x2) >> 31) / 64'd12;  sum = sum + $signed(term);
      term = ((term * x2) >> 31) / 64'd30;  sum = sum - $signed(term);
      term = ((term * x2) >> 31) / 64'd56;  sum = sum + $signed(term);
      term = ((term * x2) >> 31) / 64'd90;  sum = sum - $signed(term);
      term = ((term * x2) >> 31) / 64'd132; sum = sum + $signed(term);
      term = ((term * x2) >> 31) / 64'd182; sum = sum - $signed(term);
      term = ((term * x2) >> 31) / 64'd240; sum = sum + $signed(term);
      term = ((term * x2) >> 31) / 64'd306; sum = sum - $signed(term);
      term = ((term * x2) >> 31) / 64'd380; sum = sum + $signed(term);
      term = ((term * x2) >> 31) / 64'd462; sum = sum - $signed(term);
      term = ((term * x2) >> 31) / 64'd552; sum = sum + $signed(term);
      if (sum < 0) begin
         sum = 64'sd0;
      end
      rnd = ($unsigned(sum) + (64'd1 << 14)) >> 15;
      return rnd[16:0];
   endfunction

   function automatic cos_tab_type build_cos_tab();
      cos_tab_type t;
      for (int d = 0; d < TAB_N; d++) begin
         t[d] = cos_entry(d);
      end
      return t;
   endfunction

   localparam cos_tab_type COS_TAB = build_cos_tab();

   // signed Q1.16 cosine of a heading in 0..359
   function automatic logic signed [COS_W-1:0] cos_q16(input logic [HEADING_W-1:0] h);
      logic [HEADING_W-1:0] idx;
      logic                 neg;
      logic [COS_W-1:0]     mag;
      if (h <= HEADING_W'(QUARTER_TURN)) begin
         idx = h;
         neg = 1'b0;
      end else if (h <= HEADING_W'(HALF_TURN)) begin
         idx = HEADING_W'(HALF_TURN) - h;
         neg = 1'b1;
      end else if (h <= HEADING_W'(HALF_TURN + QUARTER_TURN)) begin
         idx = h - HEADING_W'(HALF_TURN);
         neg = 1'b1;
      end else begin
         idx = HEADING_W'(FULL_TURN) - h;
         neg = 1'b0;
      end
      mag = COS_W'(COS_TAB[idx[TAB_AW-1:0]]);
      return neg ? -$signed(mag) : $signed(mag);
   endfunction

   // intake stage
   logic                  s1_vld_ff, s1_vld_in;
   logic [CMD_W-1:0]      s1_cmd_ff;
   logic [AMOUNT_W-1:0]   s1_amount_ff;
   logic [COLOR_W-1:0]    s1_rgb_ff;
   logic [QUOT_W-1:0]     s1_quot_ff;
   logic [QUOT_W-1:0]     quot_in;
   logic [31:0]           quot_prod;
   logic                  accept;
   logic                  s1_move;
   logic                  s1_adv;

   // turtle state
   logic                  pen_down_ff, pen_down_in;
   logic [HEADING_W-1:0]  heading_ff, heading_in;
   logic [COLOR_W-1:0]    pen_color_ff, pen_color_in;

   logic [AMOUNT_W-1:0]   turn_full;
   logic [HEADING_W-1:0]  turn;
   logic [HEADING_W:0]    h_left;
   logic [HEADING_W-1:0]  h_sin;
   logic [DIST_W-1:0]     dist_mag;

   always_comb begin
      s1_move    = s1_cmd_ff inside {CMD_FWD, CMD_BACK};
      s1_adv     = s1_vld_ff && (!s1_move || !fifo_full);
      req_tready = !s1_vld_ff || s1_adv;
      accept     = req_tvalid && req_tready;
      s1_vld_in  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_ff);
      quot_prod  = 32'(req_tdata[15:0]) * 32'(TURN_RECIP);
      quot_in    = quot_prod[TURN_SHIFT +: QUOT_W];
   end

   // amount mod 360 from the registered quotient
   always_comb begin
      turn_full = s1_amount_ff - AMOUNT_W'(16'(s1_quot_ff) * 16'(FULL_TURN));
      turn      = turn_full[HEADING_W-1:0];
      h_left    = {1'b0, heading_ff} + {1'b0, turn};
   end

   always_comb begin
      pen_down_in  = pen_down_ff;
      heading_in   = heading_ff;
      pen_color_in = pen_color_ff;
      if (s1_adv) begin
         case (s1_cmd_ff)
            CMD_UP:    pen_down_in = 1'b0;
            CMD_DOWN:  pen_down_in = 1'b1;
            CMD_RIGHT: begin
               if (heading_ff >= turn) begin
                  heading_in = heading_ff - turn;
               end else begin
                  heading_in = heading_ff + HEADING_W'(FULL_TURN) - turn;
               end
            end
            CMD_LEFT: begin
               if (h_left >= (HEADING_W + 1)'(FULL_TURN)) begin
                  heading_in = HEADING_W'(h_left - (HEADING_W + 1)'(FULL_TURN));
               end else begin
                  heading_in = h_left[HEADING_W-1:0];
               end
            end
            CMD_COLOR: pen_color_in = s1_rgb_ff;
            default:   ;
         endcase
      end
   end

   // move word: sin(h) taken as cos(h + 270)
   always_comb begin
      if (heading_ff >= HEADING_W'(QUARTER_TURN)) begin
         h_sin = heading_ff - HEADING_W'(QUARTER_TURN);
      end else begin
         h_sin = heading_ff + HEADING_W'(HALF_TURN + QUARTER_TURN);
      end
      dist_mag          = {1'b0, s1_amount_ff};
      push_vld          = s1_adv && s1_move;
      push_data.travel  = (s1_cmd_ff == CMD_BACK) ? -$signed(dist_mag) : $signed(dist_mag);
      push_data.cos_val = cos_q16(heading_ff);
      push_data.sin_val = cos_q16(h_sin);
      push_data.draw    = pen_down_ff;
      push_data.color   = pen_color_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         pen_down_ff  <= 1'b0;
         heading_ff   <= '0;
         pen_color_ff <= RESET_COLOR;
      end else begin
         s1_vld_ff    <= s1_vld_in;
         pen_down_ff  <= pen_down_in;
         heading_ff   <= heading_in;
         pen_color_ff <= pen_color_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff    <= req_tuser;
         s1_amount_ff <= req_tdata[15:0];
         s1_rgb_ff    <= req_tdata[39:16];
         s1_quot_ff   <= quot_in;
      end
   end

endmodule

// ===== hdl/tsg_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsg_fifo: move word queue
// Small register queue between front and back; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module tsg_fifo import tsg_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_vld,
   input  move_type  push_data,
   output logic      full,
   output logic      pop_vld,
   input  logic      pop_rdy,
   output move_type  pop_data
);

   move_type             mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   always_comb begin
      full      = (count_ff == (FIFO_AW + 1)'(FIFO_DEPTH));
      pop_vld   = (count_ff != '0);
      pop_data  = mem_ff[rd_ptr_ff];
      do_push   = push_vld && !full;
      do_pop    = pop_vld && pop_rdy;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (FIFO_AW + 1)'(do_push) - (FIFO_AW + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/tsg_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsg_back: move execution
// Multiplies distance by cos/sin, accumulates the saturating position and
// holds the segment word in the output register.
// ----------------------------------------------------------------------------
module tsg_back import tsg_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_vld,
   output logic      pop_rdy,
   input  move_type  pop_data,
   output logic      rsp_tvalid,
   input  logic      rsp_tready,
   output seg_type   rsp_seg
);

   localparam logic signed [SUM_W-1:0] POS_HI = SUM_W'({1'b0, {(POS_W - 1){1'b1}}});
   localparam logic signed [SUM_W-1:0] POS_LO = ~POS_HI;

   function automatic logic signed [STEP_W-1:0] scale_step(
      input logic signed [PROD_W-1:0] p);
      logic                  neg;
      logic [PROD_W:0]       mag;
      logic signed [STEP_W-1:0] s;
      neg = p[PROD_W-1];
      mag = neg ? (PROD_W + 1)'(-p) : (PROD_W + 1)'(p);
      if (STEP_SHR == 0) begin
         s = STEP_W'(p);
         s = s <<< STEP_SHL;
      end else begin
         mag = (mag + (PROD_W + 1)'(STEP_RND)) >> STEP_SHR;
         s   = neg ? -$signed(STEP_W'(mag)) : $signed(STEP_W'(mag));
      end
      return s;
   endfunction

   function automatic logic signed [POS_W-1:0] sat_add(
      input logic signed [POS_W-1:0]  a,
      input logic signed [STEP_W-1:0] b);
      logic signed [SUM_W-1:0] sum;
      logic signed [SUM_W-1:0] r;
      sum = SUM_W'(a) + SUM_W'(b);
      if (sum > POS_HI) begin
         r = POS_HI;
      end else if (sum < POS_LO) begin
         r = POS_LO;
      end else begin
         r = sum;
      end
      return r[POS_W-1:0];
   endfunction

   function automatic logic [OUT_W-1:0] to_out(input logic signed [POS_W-1:0] p);
      logic signed [63:0] e;
      e = 64'(p);
      return e[OUT_W-1:0];
   endfunction

   // multiply stage
   logic                      m_vld_ff, m_vld_in;
   logic signed [PROD_W-1:0]  m_px_ff, m_py_ff;
   logic                      m_draw_ff;
   logic [COLOR_W-1:0]        m_color_ff;
   logic                      m_load;

   // accumulate stage
   logic signed [POS_W-1:0]   pos_x_ff, pos_x_in;
   logic signed [POS_W-1:0]   pos_y_ff, pos_y_in;
   logic                      out_vld_ff, out_vld_in;
   seg_type                   out_ff;
   logic                      adv;

   always_comb begin
      adv      = m_vld_ff && (!m_draw_ff || !out_vld_ff || rsp_tready);
      pop_rdy  = !m_vld_ff || adv;
      m_load   = pop_vld && pop_rdy;
      m_vld_in = m_load ? 1'b1 : (adv ? 1'b0 : m_vld_ff);
      pos_x_in = sat_add(pos_x_ff, scale_step(m_px_ff));
      pos_y_in = sat_add(pos_y_ff, scale_step(m_py_ff));
      if (adv && m_draw_ff) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
      rsp_tvalid = out_vld_ff;
      rsp_seg    = out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
      end else begin
         m_vld_ff   <= m_vld_in;
         out_vld_ff <= out_vld_in;
         if (adv) begin
            pos_x_ff <= pos_x_in;
            pos_y_ff <= pos_y_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (m_load) begin
         m_px_ff    <= PROD_W'(pop_data.travel) * PROD_W'(pop_data.cos_val);
         m_py_ff    <= PROD_W'(pop_data.travel) * PROD_W'(pop_data.sin_val);
         m_draw_ff  <= pop_data.draw;
         m_color_ff <= pop_data.color;
      end
      if (adv && m_draw_ff) begin
         out_ff.seg_color <= m_color_ff;
         out_ff.from_x    <= to_out(pos_x_ff);
         out_ff.from_y    <= to_out(pos_y_ff);
         out_ff.to_x      <= to_out(pos_x_in);
         out_ff.to_y      <= to_out(pos_y_in);
      end
   end

endmodule

// ===== hdl/turtle_segment_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// turtle_segment_generator: turtle-graphics command engine
// Turns a stream of turtle commands into a stream of drawn line segments.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one word per command. req_tuser carries the command code
//    (up, down, right, left, forward, back, set colour), req_tdata the
//    amount (degrees or distance) and the new colour.
//  - rsp channel: one word per move made while the pen is down: colour,
//    start and end point, signed fixed point with 16 fraction bits.
//  - Moves that happen with the pen up update the position silently; all
//    other commands never produce a word.
//  - Path: a drawing move taken on req passes the intake register, the move
//    queue, the multiply stage and the output register on its way to rsp.
//  - Throughput: one command per cycle unless the queue or the output word
//    stalls, bounded by the position add-and-saturate loop in the back end.
//  - Reset: pen up, position 0/0, heading 0 degrees, colour blue, queue
//    empty; req_tready is high in the first cycle after reset.
//  - When rsp_tready is low the output word holds; the back end keeps
//    executing pen-up moves, the four-entry move queue fills and
//    req_tready drops at the next move until the receiver takes the word.
// ----------------------------------------------------------------------------
module turtle_segment_generator import tsg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [2:0]    req_tuser,    // cmd[2:0]
   input  logic [39:0]   req_tdata,    // amount[15:0], rgb[39:16]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [215:0]  rsp_tdata     // seg_color[23:0], from_x[71:24],
                                       // from_y[119:72], to_x[167:120],
                                       // to_y[215:168]
);

   // front to queue
   logic      push_vld;
   move_type  push_data;
   logic      fifo_full;

   // queue to back
   logic      pop_vld;
   logic      pop_rdy;
   move_type  pop_data;

   seg_type   rsp_seg;

   // heading, pen and colour live in the front; moves are queued with the
   // trig values of the heading that was current when they were decoded
   tsg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .fifo_full  (fifo_full),
      .push_vld   (push_vld),
      .push_data  (push_data)
   );

   tsg_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_vld  (push_vld),
      .push_data (push_data),
      .full      (fifo_full),
      .pop_vld   (pop_vld),
      .pop_rdy   (pop_rdy),
      .pop_data  (pop_data)
   );

   // position accumulators and the output register
   tsg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_vld    (pop_vld),
      .pop_rdy    (pop_rdy),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_seg    (rsp_seg)
   );

   // seg_type packs seg_color in the lowest bits
   assign rsp_tdata = rsp_seg;

endmodule

// ===== hdl/tsg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsg_checker: port-level checks of the turtle segment generator
// Reset behavior of both channels and result word stability under stall.
// ----------------------------------------------------------------------------
module tsg_checker (
   input logic          clock,
   input logic          reset,
   input logic          req_tready,
   input logic          rsp_tvalid,
   input logic          rsp_tready,
   input logic [215:0]  rsp_tdata
);

   // nothing is in flight right after reset
   a_rst_rsp : assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid right after reset");

   // intake register and queue are empty after reset
   a_rst_rdy : assert property (@(posedge clock) reset |=> req_tready)
      else $error("req_tready low right after reset");

   a_hold_vld : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   a_hold_data : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result word changed while stalled");

endmodule

bind turtle_segment_generator tsg_checker u_tsg_checker (.*);

// ===== test/segment_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_checker: scoreboard for the turtle segment generator
// Watches both streams, predicts every drawn segment from the commands taken
// and compares each returned word field by field, in order.
// ----------------------------------------------------------------------------
module segment_checker import tsg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [CMD_W-1:0]   req_tuser,    // cmd[2:0]
   input  logic [39:0]        req_tdata,    // amount[15:0], rgb[39:16]
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [215:0]       rsp_tdata,    // seg_color, from_x, from_y, to_x, to_y
   output int                 mismatches,
   output int                 segs_pending
);

   localparam longint unsigned PI_Q31 = 64'd6746518852;
   localparam longint POS_HI = (longint'(1) <<< (POS_W - 1)) - 1;
   localparam longint POS_LO = -POS_HI - 1;
   localparam int SIN_SHIFT = HALF_TURN + QUARTER_TURN;  // sin(h) = cos(h + 270)

   int                 cos_q16_table [0:QUARTER_TURN];
   logic               pen_is_down;
   longint             turtle_x;
   longint             turtle_y;
   int                 turtle_heading;
   logic [COLOR_W-1:0] ink;
   seg_type            segs_due [$];

   // Taylor cosine in Q31, rounded to Q1.16
   function automatic int taylor_cos(int deg);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      int              k;
      x    = (longint'(deg) * PI_Q31) / HALF_TURN;
      x2   = (x * x) >> 31;
      term = 64'd1 << 31;
      acc  = longint'(term);
      for (k = 1; k <= 12; k++) begin
         term = ((term * x2) >> 31) / longint'((2 * k - 1) * (2 * k));
         if (k % 2 == 1)
            acc = acc - longint'(term);
         else
            acc = acc + longint'(term);
      end
      if (acc < 0)
         acc = 0;
      return int'((acc + 16384) >> 15);
   endfunction

   function automatic longint unit_cos(int h);
      h = h % FULL_TURN;
      if (h <= QUARTER_TURN)
         return cos_q16_table[h];
      if (h <= HALF_TURN)
         return -cos_q16_table[HALF_TURN - h];
      if (h <= HALF_TURN + QUARTER_TURN)
         return -cos_q16_table[h - HALF_TURN];
      return cos_q16_table[FULL_TURN - h];
   endfunction

   // distance times Q1.16 trig value, brought to the position's fraction bits
   function automatic longint scaled_step(longint travel, longint c);
      longint p;
      longint mag;
      p = travel * c;
      if (STEP_SHR == 0)
         return p <<< STEP_SHL;
      mag = (p < 0) ? -p : p;
      mag = (mag + STEP_RND) >>> STEP_SHR;
      return (p < 0) ? -mag : mag;
   endfunction

   function automatic longint clamp_add(longint a, longint b);
      if (a > POS_HI)
         a = POS_HI;
      if (a < POS_LO)
         a = POS_LO;
      if (b > 0 && a > POS_HI - b)
         return POS_HI;
      if (b < 0 && a < POS_LO - b)
         return POS_LO;
      return a + b;
   endfunction

   // apply one command to the turtle, queue the segment it draws
   task automatic take_command(logic [CMD_W-1:0] cmd, logic [AMOUNT_W-1:0] amount,
                               logic [COLOR_W-1:0] rgb);
      int      turn;
      longint  travel;
      seg_type seg;
      turn = amount % FULL_TURN;
      case (cmd)
         CMD_UP:    pen_is_down = 1'b0;
         CMD_DOWN:  pen_is_down = 1'b1;
         CMD_RIGHT: turtle_heading = (turtle_heading + FULL_TURN - turn) % FULL_TURN;
         CMD_LEFT:  turtle_heading = (turtle_heading + turn) % FULL_TURN;
         CMD_COLOR: ink = rgb;
         CMD_FWD, CMD_BACK: begin
            travel = (cmd == CMD_BACK) ? -longint'(amount) : longint'(amount);
            seg.seg_color = ink;
            seg.from_x    = turtle_x[OUT_W-1:0];
            seg.from_y    = turtle_y[OUT_W-1:0];
            turtle_x = clamp_add(turtle_x, scaled_step(travel, unit_cos(turtle_heading)));
            turtle_y = clamp_add(turtle_y,
                                 scaled_step(travel, unit_cos(turtle_heading + SIN_SHIFT)));
            seg.to_x = turtle_x[OUT_W-1:0];
            seg.to_y = turtle_y[OUT_W-1:0];
            if (pen_is_down)
               segs_due.push_back(seg);
         end
         default: ;
      endcase
   endtask

   // one line per mismatch, and every one is counted
   task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("%0t mismatch %s: got %h, want %h", $time, what, got, want);
   endtask

   task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
      if (got !== want)
         flag_mismatch(what, got, want);
   endtask

   initial begin
      int d;
      mismatches = 0;
      for (d = 0; d <= QUARTER_TURN; d++)
         cos_q16_table[d] = taylor_cos(d);
   end

   always @(posedge clock) begin : watch
      seg_type got;
      seg_type want;
      if (reset) begin
         pen_is_down    = 1'b0;
         turtle_x       = 0;
         turtle_y       = 0;
         turtle_heading = 0;
         ink            = RESET_COLOR;
         segs_due.delete();
      end else begin
         // results first: a word taken now never belongs to a command taken now
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (segs_due.size() == 0) begin
               flag_mismatch("word with no segment pending", 64'(got.seg_color), '0);
            end else begin
               want = segs_due.pop_front();
               check_field("seg_color", 64'(got.seg_color), 64'(want.seg_color));
               check_field("from_x", 64'(got.from_x), 64'(want.from_x));
               check_field("from_y", 64'(got.from_y), 64'(want.from_y));
               check_field("to_x", 64'(got.to_x), 64'(want.to_x));
               check_field("to_y", 64'(got.to_y), 64'(want.to_y));
            end
         end
         if (req_tvalid && req_tready)
            take_command(req_tuser, req_tdata[15:0], req_tdata[39:16]);
      end
      segs_pending <= segs_due.size();
   end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: turtle segment generator regression
// Directed commands, a long random command mix with random gaps and stalls,
// and pen-up runs toward both ends of both axes of the position range.
// ----------------------------------------------------------------------------
module testbench;
   import tsg_pkg::*;

   localparam logic [CMD_W-1:0] CMD_NONE = 3'd7;   // unused code, must be ignored
   localparam int RANDOM_CMDS  = 1450;
   localparam int IDLE_PCT     = 35;
   localparam int STEADY_FROM  = 600;               // random items run gap-free
   localparam int STEADY_TO    = 900;
   localparam int EDGE_PUSHES  = 16;                // full-length pen-up moves per edge
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 2_000_000;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [CMD_W-1:0]    req_tuser  = '0;   // cmd[2:0]
   logic [39:0]         req_tdata  = '0;   // amount[15:0], rgb[39:16]
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [215:0]        rsp_tdata;         // seg_color, from_x, from_y, to_x, to_y
   logic                steady     = 1'b0; // both sides stop idling
   int                  bearing    = 0;    // heading as the commands sent leave it
   int                  fails;
   int                  pending;
   int                  cycles     = 0;

   always #5 clock = ~clock;

   turtle_segment_generator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   segment_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tuser    (req_tuser),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .mismatches   (fails),
      .segs_pending (pending)
   );

   // receiver stalls at random outside the steady stretch
   always @(posedge clock)
      rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // one command word; valid stays up between back-to-back words
   task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [AMOUNT_W-1:0] amount,
                           logic [COLOR_W-1:0] rgb);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {rgb, amount};
      do @(posedge clock); while (!req_tready);
      if (cmd == CMD_RIGHT)
         bearing = (bearing + FULL_TURN - amount % FULL_TURN) % FULL_TURN;
      if (cmd == CMD_LEFT)
         bearing = (bearing + amount % FULL_TURN) % FULL_TURN;
   endtask

   // pen up, face the edge, run toward it, then draw further toward it, back and forward
   task automatic ride_edge(int face);
      int n;
      send_cmd(CMD_UP, '0, '0);
      send_cmd(CMD_LEFT, AMOUNT_W'((face + FULL_TURN - bearing) % FULL_TURN), '0);
      for (n = 0; n < EDGE_PUSHES; n++)
         send_cmd(CMD_FWD, '1, '0);
      send_cmd(CMD_DOWN, '0, '0);
      send_cmd(CMD_FWD, '1, '0);       // full-length drawn move
      send_cmd(CMD_BACK, 16'd3, '0);   // short step back
      send_cmd(CMD_FWD, 16'd5, '0);    // and forward again
   endtask

   initial begin
      int                  n;
      int                  pick;
      logic [CMD_W-1:0]    cmd;
      logic [AMOUNT_W-1:0] amount;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: silent pen-up move, zero and full-scale moves, wrap on turns,
      // colour extremes, the unused code, pen toggling
      send_cmd(CMD_FWD, 16'd100, '0);
      send_cmd(CMD_DOWN, '0, '0);
      send_cmd(CMD_FWD, '0, '0);
      send_cmd(CMD_FWD, '1, '0);
      send_cmd(CMD_BACK, '1, '0);
      send_cmd(CMD_LEFT, 16'd90, '0);
      send_cmd(CMD_FWD, 16'd1000, '0);
      send_cmd(CMD_LEFT, 16'd45, '0);
      send_cmd(CMD_BACK, 16'd300, '0);
      send_cmd(CMD_RIGHT, 16'd360, '0);
      send_cmd(CMD_RIGHT, '1, '0);          // 65535 mod 360, a turn of 15 degrees
      send_cmd(CMD_FWD, 16'd77, '0);
      send_cmd(CMD_LEFT, 16'd359, '0);
      send_cmd(CMD_COLOR, '0, '1);
      send_cmd(CMD_FWD, 16'd7, '0);
      send_cmd(CMD_COLOR, '0, '0);
      send_cmd(CMD_BACK, 16'd1, '0);
      send_cmd(CMD_NONE, '1, '1);
      send_cmd(CMD_UP, '0, '0);
      send_cmd(CMD_FWD, 16'd50, '0);
      send_cmd(CMD_DOWN, '0, '0);
      send_cmd(CMD_RIGHT, 16'd180, '0);
      send_cmd(CMD_FWD, 16'd12345, '0);
      send_cmd(CMD_LEFT, '1, '0);
      send_cmd(CMD_BACK, 16'd9, '0);

      // random mix, pen mostly down so most moves draw
      n = 0;
      while (n < RANDOM_CMDS) begin
         steady <= (n >= STEADY_FROM && n < STEADY_TO);
         pick = $urandom_range(99);
         if (pick < 25)      cmd = CMD_FWD;
         else if (pick < 40) cmd = CMD_BACK;
         else if (pick < 52) cmd = CMD_RIGHT;
         else if (pick < 64) cmd = CMD_LEFT;
         else if (pick < 78) cmd = CMD_DOWN;
         else if (pick < 84) cmd = CMD_UP;
         else if (pick < 94) cmd = CMD_COLOR;
         else                cmd = CMD_NONE;
         case ($urandom_range(9))
            0:          amount = '0;
            1:          amount = '1;
            2, 3, 4, 5: amount = AMOUNT_W'($urandom_range(400));
            default:    amount = AMOUNT_W'($urandom);
         endcase
         send_cmd(cmd, amount, COLOR_W'($urandom));
         n++;
      end

      // runs toward both ends of both axes
      steady <= 1'b1;
      ride_edge(0);
      ride_edge(QUARTER_TURN);
      ride_edge(HALF_TURN);
      ride_edge(HALF_TURN + QUARTER_TURN);
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fails == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/tsg_pkg.sv
hdl/tsg_front.sv
hdl/tsg_fifo.sv
hdl/tsg_back.sv
hdl/turtle_segment_generator.sv
hdl/tsg_checker.sv
test/segment_checker.sv
test/testbench.sv
